// ===== hdl/catr_pkg.sv =====
// ----------------------------------------------------------------------------
// catr_pkg
// shared types and constants of the reorder tracker and its slot cells
// ----------------------------------------------------------------------------
`default_nettype none

package catr_pkg;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int TAG_W  = 8;
    localparam int KIND_W = 2;

    localparam int SLOTS_DEF    = 8;
    localparam int MAX_DATA_DEF = 1024;

    // results one segment may cause, deliveries plus the closing ack
    localparam int MAX_RESULTS = 10;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // slave tdata: seq, length, tag
    localparam int S_TDATA_W = 56;
    // master tdata: seq, length, tag, ack, dropped
    localparam int M_TDATA_W = 88;
    localparam int ACK_LSB   = SEQ_W + LEN_W + TAG_W;
    localparam int DROP_BIT  = ACK_LSB + SEQ_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_END     = 2'd2,
        KIND_REJECT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } t_seg;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [SEQ_W-1:0] key;
        logic             store_en;
        logic             take_en;
        t_seg             seg;
    } t_cell_cmd;

    // handed from each cell to the next one up the row
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
        t_seg hit_seg;
    } t_cell_chain;

    typedef struct packed {
        t_kind            kind;
        t_seg             seg;
        logic [SEQ_W-1:0] ack;
        logic             dropped;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/cumulative_ack_reorder_tracker.sv =====
// ----------------------------------------------------------------------------
// cumulative_ack_reorder_tracker
// receive-side reorder tracker with cumulative acknowledgement
// ----------------------------------------------------------------------------
// Each slave transfer is one segment descriptor. After acceptance the block
// decides on it in the decide state: an over-length segment, an end-of-stream
// marker or an out-of-order segment gives a single result, and the block
// returns to idle before the next segment is taken. An in-order segment
// is delivered in the decide state and then the held segments that continue
// the stream are drained one per cycle while the output is not stalled,
// each drain step being one compare of the expected number against all
// slot cells; the closing ack follows after at most 8 drained segments. Any
// cycle in which the single output register is full and not taken holds
// the decide and drain states. The slots are a row of SLOTS cells; the lowest
// matching and the lowest free slot are found through the chain along the row.
// Writing the configuration channel (taken only while idle) loads the
// expected sequence number. After an end-of-stream segment every later
// segment is accepted and discarded until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cumulative_ack_reorder_tracker #(
    parameter int SLOTS    = catr_pkg::SLOTS_DEF,
    parameter int MAX_DATA = catr_pkg::MAX_DATA_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write: initial sequence number
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [catr_pkg::SEQ_W-1:0]       i_cfg_data,
    // segment stream in
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // seq_number[31:0], data_length[42:32], payload_tag[50:43], zero fill
    input  wire  [catr_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // result stream out
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // out_seq[31:0], out_length[42:32], out_tag[50:43], ack_number[82:51],
    // store_dropped[83], zero fill
    output logic [catr_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // kind[1:0]
    output logic [catr_pkg::KIND_W-1:0]      o_m_tuser,
    output logic                             o_m_tlast
);
    import catr_pkg::*;

    // sequencer
    t_state           r_state, n_state;
    t_seg             r_seg;
    logic [SEQ_W-1:0] r_expected, n_expected;
    logic             r_ended, n_ended;
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic             r_m_valid;
    t_result          r_res, n_res;
    logic             n_emit;
    logic             w_out_free;

    // slot row
    t_cell_cmd        w_cmd;
    t_cell_chain      w_chain [SLOTS+1];

    logic             w_s_xfer;
    logic [SEQ_W-1:0] w_diff;
    logic             w_ahead;

    assign w_out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;

    // serial-number ahead test
    assign w_diff  = r_seg.seq - r_expected;
    assign w_ahead = (w_diff != '0) && !w_diff[SEQ_W-1];

    assign w_chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        catr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_expected = r_expected;
        n_ended    = r_ended;
        n_count    = r_count;
        n_emit     = 1'b0;
        n_res      = '0;
        w_cmd      = '0;
        w_cmd.seg  = r_seg;
        // decide looks up the new segment, drain looks up the continuation
        w_cmd.key  = (r_state == S_DRAIN) ? r_expected : r_seg.seq;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_expected = i_cfg_data;
                end
                if (w_s_xfer && !r_ended) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    n_emit = 1'b1;
                    if (r_seg.len > LEN_W'(MAX_DATA)) begin
                        n_res.kind = KIND_REJECT;
                        n_res.last = 1'b1;
                        n_state    = S_IDLE;
                    end else if (r_seg.len == '0) begin
                        n_res.kind = KIND_END;
                        n_res.last = 1'b1;
                        n_ended    = 1'b1;
                        n_state    = S_IDLE;
                    end else if (r_seg.seq == r_expected) begin
                        n_res.kind = KIND_DELIVER;
                        n_res.seg  = r_seg;
                        n_expected = r_seg.seq + SEQ_W'(r_seg.len);
                        n_count    = CNT_W'(1);
                        n_state    = S_DRAIN;
                    end else begin
                        // out of order: ack now, hold it if ahead and new
                        n_res.kind = KIND_ACK;
                        n_res.ack  = r_expected;
                        n_res.last = 1'b1;
                        if (w_ahead && !w_chain[SLOTS].hit_seen) begin
                            w_cmd.store_en = w_chain[SLOTS].free_seen;
                            n_res.dropped  = !w_chain[SLOTS].free_seen;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    n_emit = 1'b1;
                    if (w_chain[SLOTS].hit_seen && (r_count < CNT_W'(MAX_RESULTS - 1))) begin
                        n_res.kind    = KIND_DELIVER;
                        n_res.seg     = w_chain[SLOTS].hit_seg;
                        w_cmd.take_en = 1'b1;
                        n_expected    = w_chain[SLOTS].hit_seg.seq
                                      + SEQ_W'(w_chain[SLOTS].hit_seg.len);
                        n_count       = r_count + CNT_W'(1);
                    end else begin
                        n_res.kind = KIND_ACK;
                        n_res.ack  = r_expected;
                        n_res.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_expected <= '0;
            r_ended    <= 1'b0;
            r_count    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_expected <= n_expected;
            r_ended    <= n_ended;
            r_count    <= n_count;
            if (n_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_seg.seq <= i_s_tdata[SEQ_W-1:0];
            r_seg.len <= i_s_tdata[SEQ_W+LEN_W-1:SEQ_W];
            r_seg.tag <= i_s_tdata[SEQ_W+LEN_W+TAG_W-1:SEQ_W+LEN_W];
        end
        if (n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;
    assign o_m_tdata  = {(M_TDATA_W - DROP_BIT - 1)'(0), r_res.dropped, r_res.ack,
                         r_res.seg.tag, r_res.seg.len, r_res.seg.seq};

endmodule

`default_nettype wire

// ===== hdl/catr_cell.sv =====
// ----------------------------------------------------------------------------
// catr_cell
// one segment slot: match against the broadcast key, lowest hit and lowest
// free slot resolved by the chain from the neighbour below
// ----------------------------------------------------------------------------
`default_nettype none

module catr_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  catr_pkg::t_cell_cmd    i_cmd,
    input  catr_pkg::t_cell_chain  i_chain,
    output catr_pkg::t_cell_chain  o_chain
);
    import catr_pkg::*;

    logic r_valid;
    t_seg r_seg;
    logic w_hit;
    logic w_sel_hit;
    logic w_sel_free;

    assign w_hit      = r_valid && (r_seg.seq == i_cmd.key);
    assign w_sel_hit  = w_hit && !i_chain.hit_seen;
    assign w_sel_free = !r_valid && !i_chain.free_seen;

    always_comb begin
        o_chain.hit_seen  = i_chain.hit_seen | w_hit;
        o_chain.free_seen = i_chain.free_seen | !r_valid;
        o_chain.hit_seg   = i_chain.hit_seg | (w_sel_hit ? r_seg : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.store_en && w_sel_free) begin
            r_valid <= 1'b1;
        end else if (i_cmd.take_en && w_sel_hit) begin
            r_valid <= 1'b0;
        end
    end

    // payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_en && w_sel_free) begin
            r_seg <= i_cmd.seg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/catr_checker.sv =====
// ----------------------------------------------------------------------------
// catr_checker
// port-level checks of the reorder tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module catr_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_m_tvalid,
    input wire                            i_m_tready,
    input wire [catr_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input wire [catr_pkg::KIND_W-1:0]     o_m_tuser,
    input wire                            o_m_tlast
);
    import catr_pkg::*;

    // nothing offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // a delivery is never the final result of its segment
    a_deliver_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_DELIVER) |-> !o_m_tlast)
        else $error("delivery marked last");

    // end and reject results close their segment and carry no drop flag
    a_single_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == KIND_END) || (o_m_tuser == KIND_REJECT))
            |-> o_m_tlast && !o_m_tdata[DROP_BIT])
        else $error("malformed end or reject result");

    // a drop flag only on an ack
    a_drop_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[DROP_BIT] |-> (o_m_tuser == KIND_ACK) && o_m_tlast)
        else $error("drop flag outside an ack");

endmodule

bind cumulative_ack_reorder_tracker catr_checker u_catr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// ===== test/cumulative_ack_reorder_tracker_test.sv =====
// ----------------------------------------------------------------------------
// cumulative_ack_reorder_tracker_test
// self-checking bench for the receive-side reorder tracker
// ----------------------------------------------------------------------------
// Segment descriptors go in on the slave stream. Every accepted transfer is
// run through a behavioural copy of the tracker kept here, and the results
// that it should cause are queued. Each result transfer on the master stream
// is taken against the oldest queued one, field by field. Directed tests hit
// in-order delivery, over-length rejects, reordering with drains, a full
// slot store, the edge of the ahead window, stale slots, sequence wrap and
// end of stream; random traffic sends shuffled runs of contiguous segments
// with duplicates, drops, retransmissions and stray segments mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cumulative_ack_reorder_tracker_test;

    import catr_pkg::*;

    localparam int SLOT_COUNT  = SLOTS_DEF;
    localparam int MAX_LEN     = MAX_DATA_DEF;
    localparam int FILL_W      = S_TDATA_W - SEQ_W - LEN_W - TAG_W;
    localparam int ITEM_TARGET = 270;
    localparam int SETTLE      = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_RUN     = 12;

    // one result transfer as the bench expects it
    typedef struct packed {
        t_kind            kind;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] ack;
        logic             dropped;
        logic             last;
    } seg_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic [SEQ_W-1:0]     cfg_data  = '0;
    logic                 cfg_ready;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    // behavioural copy of the tracker state
    logic [SEQ_W-1:0] next_byte = '0;
    bit               held_valid [SLOT_COUNT];
    logic [SEQ_W-1:0] held_seq   [SLOT_COUNT];
    logic [LEN_W-1:0] held_len   [SLOT_COUNT];
    logic [TAG_W-1:0] held_tag   [SLOT_COUNT];
    bit               stream_closed = 1'b0;

    seg_result_t awaited_results [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    bit steady_sender  = 1'b0;
    int rx_count       = 0;
    int rx_mode        = 0;
    int rx_hold        = 0;

    always #5 i_clk = ~i_clk;

    cumulative_ack_reorder_tracker #(
        .SLOTS    (SLOT_COUNT),
        .MAX_DATA (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        // seq_number[31:0], data_length[42:32], payload_tag[50:43], zero fill
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        // out_seq[31:0], out_length[42:32], out_tag[50:43], ack_number[82:51],
        // store_dropped[83], zero fill
        .o_m_tdata   (m_tdata),
        // kind[1:0]
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------------
    // expected behaviour
    // ------------------------------------------------------------------------

    function automatic seg_result_t make_result(t_kind kind, logic [SEQ_W-1:0] seq,
                                                logic [LEN_W-1:0] len,
                                                logic [TAG_W-1:0] tag,
                                                logic [SEQ_W-1:0] ack,
                                                logic dropped, logic last);
        seg_result_t r;
        r.kind    = kind;
        r.seq     = seq;
        r.len     = len;
        r.tag     = tag;
        r.ack     = ack;
        r.dropped = dropped;
        r.last    = last;
        return r;
    endfunction

    function automatic bit is_held(logic [SEQ_W-1:0] seq);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (held_valid[i] && held_seq[i] == seq)
                return 1'b1;
        return 1'b0;
    endfunction

    // works out the results of one accepted segment and queues them
    task automatic reassemble_segment(input logic [SEQ_W-1:0] seq,
                                      input logic [LEN_W-1:0] len,
                                      input logic [TAG_W-1:0] tag);
        int               hit;
        int               emitted;
        int               free_slot;
        bit               already_held;
        logic [SEQ_W-1:0] distance;
        logic             no_room;

        // after end of stream everything is swallowed
        if (stream_closed)
            return;
        if (len > MAX_LEN) begin
            awaited_results.push_back(make_result(KIND_REJECT, '0, '0, '0, '0, 1'b0, 1'b1));
            return;
        end
        if (len == '0) begin
            stream_closed = 1'b1;
            awaited_results.push_back(make_result(KIND_END, '0, '0, '0, '0, 1'b0, 1'b1));
            return;
        end

        if (seq == next_byte) begin
            awaited_results.push_back(make_result(KIND_DELIVER, seq, len, tag, '0, 1'b0, 1'b0));
            next_byte = seq + SEQ_W'(len);
            emitted   = 1;
            // drain held continuations, lowest matching slot first
            while (emitted < MAX_RESULTS - 1) begin
                hit = -1;
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (hit < 0 && held_valid[i] && held_seq[i] == next_byte)
                        hit = i;
                if (hit < 0)
                    break;
                awaited_results.push_back(make_result(KIND_DELIVER, held_seq[hit],
                                                      held_len[hit], held_tag[hit],
                                                      '0, 1'b0, 1'b0));
                next_byte       = held_seq[hit] + SEQ_W'(held_len[hit]);
                held_valid[hit] = 1'b0;
                emitted++;
            end
            awaited_results.push_back(make_result(KIND_ACK, '0, '0, '0, next_byte, 1'b0, 1'b1));
            return;
        end

        // out of order: store only if ahead in serial arithmetic
        distance = seq - next_byte;
        no_room  = 1'b0;
        if (distance != '0 && distance < 32'h8000_0000) begin
            already_held = 1'b0;
            free_slot    = -1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (held_valid[i]) begin
                    if (held_seq[i] == seq)
                        already_held = 1'b1;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (!already_held) begin
                if (free_slot >= 0) begin
                    held_valid[free_slot] = 1'b1;
                    held_seq[free_slot]   = seq;
                    held_len[free_slot]   = len;
                    held_tag[free_slot]   = tag;
                end else begin
                    no_room = 1'b1;
                end
            end
        end
        awaited_results.push_back(make_result(KIND_ACK, '0, '0, '0, next_byte, no_room, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one segment transfer; the sender idles between bursts unless steady
    task automatic send_segment(input logic [SEQ_W-1:0] seq,
                                input logic [LEN_W-1:0] len,
                                input logic [TAG_W-1:0] tag);
        if (burst_left == 0) begin
            if (!steady_sender) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{FILL_W{1'b0}}, tag, len, seq};
        do @(posedge i_clk); while (!s_tready);
        reassemble_segment(seq, len, tag);
        items_sent++;
    endtask

    // hold off until every queued result has come, then let the block settle
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // loads the initial sequence number; slots are left as they are
    task automatic write_config(input logic [SEQ_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        next_byte = value;
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        seg_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result of kind %0d with nothing awaited", m_tuser));
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[0 +: SEQ_W] !== want.seq)
                    report_mismatch($sformatf("out_seq %h, want %h",
                                              m_tdata[0 +: SEQ_W], want.seq));
                if (m_tdata[SEQ_W +: LEN_W] !== want.len)
                    report_mismatch($sformatf("out_length %0d, want %0d",
                                              m_tdata[SEQ_W +: LEN_W], want.len));
                if (m_tdata[SEQ_W + LEN_W +: TAG_W] !== want.tag)
                    report_mismatch($sformatf("out_tag %h, want %h",
                                              m_tdata[SEQ_W + LEN_W +: TAG_W], want.tag));
                if (m_tdata[ACK_LSB +: SEQ_W] !== want.ack)
                    report_mismatch($sformatf("ack_number %h, want %h",
                                              m_tdata[ACK_LSB +: SEQ_W], want.ack));
                if (m_tdata[DROP_BIT] !== want.dropped)
                    report_mismatch($sformatf("store_dropped %b, want %b",
                                              m_tdata[DROP_BIT], want.dropped));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
            end
        end
    end

    // receiver back-pressure: free flow, coin-toss, or occasional long stalls
    always @(posedge i_clk) begin
        rx_count++;
        if (rx_count % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        rx_hold = $urandom_range(2, 9);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_in_order_delivery();
        send_segment(next_byte, 11'd100, 8'h00);
        send_segment(next_byte, LEN_W'(MAX_LEN), 8'hFF);
    endtask

    task automatic test_over_length_reject();
        send_segment($urandom, LEN_W'(MAX_LEN + 1), TAG_W'($urandom));
        send_segment($urandom, 11'h7FF, TAG_W'($urandom));
    endtask

    // two segments arrive ahead in reverse, a stale repeat, then the gap fills
    task automatic test_reorder_and_drain();
        logic [SEQ_W-1:0] base;
        base = next_byte;
        send_segment(base + 32'd100, 11'd30, 8'hC3);
        send_segment(base + 32'd40, 11'd60, 8'hB2);
        send_segment(base - 32'd1, 11'd1, 8'h5A);
        send_segment(base, 11'd40, 8'hA1);
    endtask

    // fill every slot, overflow one, repeat a held one, then drain the lot
    task automatic test_store_full();
        localparam int SEG = 16;
        logic [SEQ_W-1:0] base;
        base = next_byte;
        for (int i = SLOT_COUNT; i >= 1; i--)
            send_segment(base + SEQ_W'(i * SEG), LEN_W'(SEG), TAG_W'(i));
        send_segment(base + SEQ_W'((SLOT_COUNT + 1) * SEG), LEN_W'(SEG), 8'h99);
        send_segment(base + SEQ_W'(3 * SEG), LEN_W'(SEG), 8'h33);
        // let everything come out before the gap is filled
        wait_for_results();
        send_segment(base, LEN_W'(SEG), 8'h80);
        send_segment(base + SEQ_W'((SLOT_COUNT + 1) * SEG), LEN_W'(SEG), 8'h99);
    endtask

    // half a sequence space away is not ahead, one less is
    task automatic test_ahead_window_edge();
        logic [SEQ_W-1:0] base;
        base = next_byte;
        send_segment(base + 32'h8000_0000, 11'd10, 8'h11);
        send_segment(base + 32'h7FFF_FFFF, 11'd10, 8'h22);
        // pull the far segment out again through a fresh start just below it
        write_config(base + 32'h7FFF_FFFF - 32'd20);
        send_segment(next_byte, 11'd20, 8'h44);
    endtask

    // a held segment overtaken by an overlapping one stays put
    task automatic test_stale_slot();
        logic [SEQ_W-1:0] base;
        base = next_byte;
        send_segment(base + 32'd50, 11'd10, 8'h66);
        send_segment(base, 11'd100, 8'h77);
        // the store survives a config write, so the old entry drains here
        write_config(base + 32'd30);
        send_segment(base + 32'd30, 11'd20, 8'h88);
    endtask

    task automatic test_sequence_wrap();
        write_config(32'hFFFF_FFFF);
        send_segment(32'hFFFF_FFFF, 11'd1, 8'hE1);
        write_config(32'hFFFF_FF00);
        send_segment(32'hFFFF_FF00, LEN_W'(MAX_LEN), 8'hE2);
        write_config(32'h0000_0000);
        send_segment(32'h0000_0000, 11'd7, 8'hE3);
    endtask

    // shuffled runs of contiguous segments, retransmitted until complete
    task automatic test_random_traffic();
        logic [SEQ_W-1:0] run_start [MAX_RUN];
        logic [LEN_W-1:0] run_len   [MAX_RUN];
        logic [TAG_W-1:0] run_tag   [MAX_RUN];
        int               order     [MAX_RUN];
        int               seg_count;
        int               pick;
        int               swap;
        logic [SEQ_W-1:0] run_end;

        while (items_sent < ITEM_TARGET) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                write_config($urandom);

            // stray segments behind the window, often over-length as well
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_segment(next_byte - SEQ_W'($urandom_range(1, 32'h8000_0000)),
                                 LEN_W'($urandom_range(1, 2047)), TAG_W'($urandom));

            seg_count = $urandom_range(1, MAX_RUN - 1);
            run_end   = next_byte;
            for (int k = 0; k < seg_count; k++) begin
                run_start[k] = run_end;
                run_len[k]   = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(1, MAX_LEN))
                                                           : LEN_W'($urandom_range(1, 64));
                run_tag[k]   = TAG_W'($urandom);
                run_end      = run_end + SEQ_W'(run_len[k]);
                order[k]     = k;
            end
            for (int k = seg_count - 1; k > 0; k--) begin
                pick        = $urandom_range(0, k);
                swap        = order[k];
                order[k]    = order[pick];
                order[pick] = swap;
            end

            for (int k = 0; k < seg_count; k++) begin
                send_segment(run_start[order[k]], run_len[order[k]], run_tag[order[k]]);
                // occasional duplicate of something already sent
                if ($urandom_range(0, 9) == 0) begin
                    pick = order[$urandom_range(0, k)];
                    send_segment(run_start[pick], run_len[pick], run_tag[pick]);
                end
            end

            // resend whatever is still missing, in a fresh order each round
            while (next_byte != run_end) begin
                for (int k = seg_count - 1; k > 0; k--) begin
                    pick        = $urandom_range(0, k);
                    swap        = order[k];
                    order[k]    = order[pick];
                    order[pick] = swap;
                end
                for (int k = 0; k < seg_count; k++) begin
                    pick = order[k];
                    if ((run_start[pick] - next_byte) < 32'h8000_0000 &&
                        !is_held(run_start[pick]))
                        send_segment(run_start[pick], run_len[pick], run_tag[pick]);
                end
            end
        end
        steady_sender = 1'b0;
    endtask

    // zero length closes the stream; later segments are swallowed
    task automatic test_end_of_stream();
        send_segment(next_byte, 11'd0, TAG_W'($urandom));
        send_segment(next_byte, 11'd10, TAG_W'($urandom));
        send_segment($urandom, LEN_W'(MAX_LEN + 5), TAG_W'($urandom));
        send_segment(next_byte, 11'd0, TAG_W'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_in_order_delivery();
        test_over_length_reject();
        test_reorder_and_drain();
        test_store_full();
        test_ahead_window_edge();
        test_stale_slot();
        test_sequence_wrap();
        test_random_traffic();
        test_end_of_stream();

        wait_for_results();
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
